// ===== rtl/core/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Shared widths, operation and status codes, and the result bundle of the
// bounded list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ble_pkg;

  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;
  localparam int ENT_W  = 5;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEL_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DEL_TAIL = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_KEY  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SUM      = 3'd5;
  localparam logic [FUNC_W-1:0] FN_MAX      = 3'd6;
  localparam logic [FUNC_W-1:0] FN_ADD      = 3'd7;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
    logic [ENT_W-1:0]  entries;
  } res_t;

endpackage

// ===== rtl/core/bounded_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_list_engine_unit
// Ordered list of up to CAPACITY signed 32-bit keys with head/tail/key
// operations, search, sum, maximum and ranged add.
// ----------------------------------------------------------------------------
// Usage:
//   Send one operation per transfer on the in_ channel (in_func, in_key,
//   in_amount). Every operation returns exactly one transfer on the out_
//   channel with the value, the status and the number of entries held.
//   The block works on one operation at a time; the next one is accepted
//   once the current result has moved into the output register.
//   From accept to the output register: insert head, and any operation
//   that finds the list empty or full, goes straight to the result; delete
//   head and delete tail read the store once; delete key, search, sum,
//   max and add walk the entries held at one read per cycle through the
//   store's single read port (search stops at the first match).
//   Reset empties the list at once; the store contents are never read
//   before they are written, so no clearing pass runs.
//   A stalled receiver holds the result in the output register; one more
//   operation may be accepted and worked off, and it then waits for the
//   register to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ble_pkg::FUNC_W-1:0] in_func,
  input  logic [ble_pkg::DATA_W-1:0] in_key,
  input  logic [ble_pkg::DATA_W-1:0] in_amount,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ble_pkg::DATA_W-1:0] out_value,
  output logic [ble_pkg::STAT_W-1:0] out_status,
  output logic [ble_pkg::ENT_W-1:0]  out_entries
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [ble_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [ble_pkg::DATA_W-1:0] mem_rdata;

  logic                       res_valid;
  logic                       res_ready;
  ble_pkg::res_t              res;

  logic                       out_valid_r;
  ble_pkg::res_t              out_res_r;

  ble_ram #(
    .AW(AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  ble_seq #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_key   (in_key),
    .in_amount(in_amount),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_value   = out_res_r.value;
  assign out_status  = out_res_r.status;
  assign out_entries = out_res_r.entries;

endmodule

// ===== rtl/core/ble_ram.sv =====
// ----------------------------------------------------------------------------
// ble_ram
// Single write port, single read port key store with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ble_ram #(
  parameter int AW = 4
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ble_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [ble_pkg::DATA_W-1:0] rdata
);

  logic [ble_pkg::DATA_W-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ble_seq.sv =====
// ----------------------------------------------------------------------------
// ble_seq
// Operation sequencer: keeps the list as a circular buffer in the store,
// walks entries one read per cycle and writes modified entries back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ble_seq #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ble_pkg::FUNC_W-1:0] in_func,
  input  logic [ble_pkg::DATA_W-1:0] in_key,
  input  logic [ble_pkg::DATA_W-1:0] in_amount,
  output logic                       res_valid,
  input  logic                       res_ready,
  output ble_pkg::res_t              res,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [ble_pkg::DATA_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [AW-1:0]              mem_raddr,
  input  logic [ble_pkg::DATA_W-1:0] mem_rdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ1 = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [1:0]                  state_r, state_nxt;
  logic [ble_pkg::FUNC_W-1:0]  func_r, func_nxt;
  logic [ble_pkg::DATA_W-1:0]  key_r, key_nxt;
  logic [ble_pkg::DATA_W-1:0]  amt_r, amt_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               iss_r, iss_nxt;
  logic                        rv_r, rv_nxt;
  logic [CW-1:0]               ridx_r, ridx_nxt;
  logic                        matched_r, matched_nxt;
  logic [ble_pkg::DATA_W-1:0]  acc_r, acc_nxt;
  logic [ble_pkg::DATA_W-1:0]  val_r, val_nxt;
  logic [ble_pkg::STAT_W-1:0]  st_r, st_nxt;

  logic [CW-1:0]               last_idx;
  logic [AW-1:0]               paddr;
  logic                        is_last;
  logic                        hit;
  logic [ble_pkg::DATA_W-1:0]  mx;
  logic [31:0]                 cnt_ext;

  assign last_idx = count_r - CW'(1);
  assign paddr    = head_r + ridx_r[AW-1:0];
  assign is_last  = (ridx_r == last_idx);
  assign hit      = (mem_rdata == key_r);
  assign mx       = ((ridx_r == '0) || ($signed(mem_rdata) > $signed(acc_r))) ?
                    mem_rdata : acc_r;
  assign cnt_ext  = 32'(count_r);

  assign in_ready    = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res.value   = val_r;
  assign res.status  = st_r;
  assign res.entries = cnt_ext[ble_pkg::ENT_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    key_nxt     = key_r;
    amt_nxt     = amt_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    iss_nxt     = iss_r;
    rv_nxt      = 1'b0;
    ridx_nxt    = ridx_r;
    matched_nxt = matched_r;
    acc_nxt     = acc_r;
    val_nxt     = val_r;
    st_nxt      = st_r;
    mem_we      = 1'b0;
    mem_waddr   = head_r;
    mem_wdata   = key_r;
    mem_re      = 1'b0;
    mem_raddr   = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt    = in_func;
          key_nxt     = in_key;
          amt_nxt     = in_amount;
          acc_nxt     = '0;
          matched_nxt = 1'b0;
          iss_nxt     = '0;
          val_nxt     = '0;
          st_nxt      = ble_pkg::ST_OK;
          case (in_func)
            ble_pkg::FN_INS_HEAD: begin
              if (count_r == CAP_CNT) begin
                st_nxt = ble_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = head_r - AW'(1);
                mem_wdata = in_key;
                head_nxt  = head_r - AW'(1);
                count_nxt = count_r + CW'(1);
              end
              state_nxt = S_DONE;
            end
            ble_pkg::FN_DEL_HEAD: begin
              if (count_r == '0) begin
                st_nxt    = ble_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r;
                state_nxt = S_READ1;
              end
            end
            ble_pkg::FN_DEL_TAIL: begin
              if (count_r == '0) begin
                st_nxt    = ble_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_r + last_idx[AW-1:0];
                state_nxt = S_READ1;
              end
            end
            ble_pkg::FN_SUM: begin
              state_nxt = (count_r == '0) ? S_DONE : S_WALK;
            end
            default: begin
              if (count_r == '0) begin
                st_nxt    = ble_pkg::ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
          endcase
        end
      end

      S_READ1: begin
        val_nxt   = mem_rdata;
        count_nxt = count_r - CW'(1);
        if (func_r == ble_pkg::FN_DEL_HEAD) begin
          head_nxt = head_r + AW'(1);
        end
        state_nxt = S_DONE;
      end

      S_WALK: begin
        // keep one read in flight ahead of the entry being processed
        if (iss_r < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = head_r + iss_r[AW-1:0];
          rv_nxt    = 1'b1;
          ridx_nxt  = iss_r;
          iss_nxt   = iss_r + CW'(1);
        end
        if (rv_r) begin
          case (func_r)
            ble_pkg::FN_SUM: begin
              acc_nxt = acc_r + mem_rdata;
              if (is_last) begin
                val_nxt   = acc_r + mem_rdata;
                state_nxt = S_DONE;
              end
            end
            ble_pkg::FN_MAX: begin
              acc_nxt = mx;
              if (is_last) begin
                val_nxt   = mx;
                state_nxt = S_DONE;
              end
            end
            ble_pkg::FN_SEARCH: begin
              if (hit) begin
                state_nxt = S_DONE;
              end else if (is_last) begin
                st_nxt    = ble_pkg::ST_NOTFOUND;
                state_nxt = S_DONE;
              end
            end
            ble_pkg::FN_DEL_KEY: begin
              // close the gap: move every later entry down by one
              if (matched_r) begin
                mem_we    = 1'b1;
                mem_waddr = paddr - AW'(1);
                mem_wdata = mem_rdata;
              end else if (hit) begin
                matched_nxt = 1'b1;
                val_nxt     = mem_rdata;
              end
              if (is_last) begin
                if (matched_r || hit) begin
                  count_nxt = count_r - CW'(1);
                end else begin
                  st_nxt = ble_pkg::ST_NOTFOUND;
                end
                state_nxt = S_DONE;
              end
            end
            ble_pkg::FN_ADD: begin
              if (matched_r || hit) begin
                mem_we      = 1'b1;
                mem_waddr   = paddr;
                mem_wdata   = mem_rdata + amt_r;
                matched_nxt = 1'b1;
              end
              if (is_last) begin
                if (!(matched_r || hit)) begin
                  st_nxt = ble_pkg::ST_NOTFOUND;
                end
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      iss_r     <= '0;
      rv_r      <= 1'b0;
      matched_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      iss_r     <= iss_nxt;
      rv_r      <= rv_nxt;
      matched_r <= matched_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    key_r  <= key_nxt;
    amt_r  <= amt_nxt;
    ridx_r <= ridx_nxt;
    acc_r  <= acc_nxt;
    val_r  <= val_nxt;
    st_r   <= st_nxt;
  end

endmodule

// ===== rtl/core/ble_unit_chk.sv =====
// ----------------------------------------------------------------------------
// ble_unit_chk
// Port-level checks on the result channel of the bounded list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ble_unit_chk #(
  parameter int CAPACITY = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ble_pkg::DATA_W-1:0] out_value,
  input logic [ble_pkg::STAT_W-1:0] out_status,
  input logic [ble_pkg::ENT_W-1:0]  out_entries
);

  localparam logic [ble_pkg::ENT_W-1:0] CAP_ENT = ble_pkg::ENT_W'(CAPACITY);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_status) && $stable(out_entries))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ble_pkg::ST_EMPTY |->
      out_value == '0 && out_entries == '0)
    else $error("empty status with nonzero value or entries");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ble_pkg::ST_FULL |->
      out_value == '0 && out_entries == CAP_ENT)
    else $error("full status without a full list");

  a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ble_pkg::ST_NOTFOUND |-> out_value == '0)
    else $error("key not found with nonzero value");

endmodule

bind bounded_list_engine_unit ble_unit_chk #(.CAPACITY(CAPACITY)) u_chk (.*);
